// ----- rtl/srrw_pkg.sv -----
// Shared constants and controller/datapath interface types for the receiver window.
`default_nettype none
package srrw_pkg;

	localparam int POS_W      = 16;
	localparam int WINDOW_DEF = 8;

	localparam logic [POS_W-1:0] POS_MAX  = 16'hFFFF;
	localparam logic [POS_W-1:0] BASE_RST = 16'd1;

	localparam logic KIND_DELIV = 1'b0;
	localparam logic KIND_ACK   = 1'b1;

	typedef struct packed {
		logic cap;
		logic eval_hit;
		logic eval_other;
		logic take;
		logic emit_mem;
		logic emit_ack;
	} srrw_cmd_t;

	typedef struct packed {
		logic hit;
		logic sat;
		logic pres;
		logic nfull;
		logic out_free;
	} srrw_stat_t;

endpackage
`default_nettype wire

// ----- rtl/srrw_ctrl.sv -----
// Controller state machine sequencing evaluation, drain and ack of one item.
`default_nettype none
module srrw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire srrw_pkg::srrw_stat_t stat,
	output srrw_pkg::srrw_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_ACK  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.out_free) begin
					if (stat.hit) begin
						cmd.eval_hit = 1'b1;
						state_d      = stat.sat ? ST_ACK : ST_CHK;
					end else begin
						cmd.eval_other = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			ST_CHK: begin
				if (stat.nfull || !stat.pres) begin
					state_d = ST_ACK;
				end else begin
					cmd.take = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_mem = 1'b1;
					state_d      = stat.sat ? ST_ACK : ST_CHK;
				end
			end
			ST_ACK: begin
				if (stat.out_free) begin
					cmd.emit_ack = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/srrw_dp.sv -----
// Datapath: window base, slot flags, handle memory, window compare and output register.
`default_nettype none
module srrw_dp #(
	parameter int WINDOW = srrw_pkg::WINDOW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [srrw_pkg::POS_W-1:0]   seq,
	input  wire logic [srrw_pkg::POS_W-1:0]   tag,
	input  wire logic                         checksum_ok,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              kind,
	output logic [srrw_pkg::POS_W-1:0]        position,
	output logic [srrw_pkg::POS_W-1:0]        handle,
	output logic                              ack_valid,
	output logic                              last,
	input  wire srrw_pkg::srrw_cmd_t          cmd,
	output srrw_pkg::srrw_stat_t              stat
);

	localparam int PW = srrw_pkg::POS_W;
	localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int NW = $clog2(WINDOW + 1);
	localparam logic [SW:0]   WIN_S    = (SW+1)'(WINDOW);
	localparam logic [SW-1:0] SLOT_TOP = SW'(WINDOW - 1);
	localparam logic [SW-1:0] SLOT_RST = SW'(1 % WINDOW);
	localparam logic [PW:0]   WIN_P    = (PW+1)'(WINDOW);
	localparam logic [NW-1:0] N_FULL   = NW'(WINDOW);

	logic [PW-1:0]     seq_q;
	logic [PW-1:0]     tag_q;
	logic              ok_q;
	logic [PW-1:0]     base_q;
	logic [SW-1:0]     base_slot_q;
	logic [WINDOW-1:0] present_q;
	logic [NW-1:0]     n_q;
	logic [PW-1:0]     mem [WINDOW];
	logic [PW-1:0]     rdata_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [PW-1:0]     position_q;
	logic [PW-1:0]     handle_q;
	logic              ack_valid_q;
	logic              last_q;

	logic              pkt_ok;
	logic [PW-1:0]     pos;
	logic              ge;
	logic [PW:0]       up;
	logic [PW:0]       dn;
	logic              in_win;
	logic              below;
	logic [SW:0]       slot_sum;
	logic [SW-1:0]     slot;
	logic              store_en;
	logic              other_ack;
	logic              sat;
	logic              out_free;
	logic              adv;

	assign pkt_ok   = ok_q && (seq_q != srrw_pkg::POS_MAX);
	assign pos      = seq_q + PW'(1);
	assign ge       = pos >= base_q;
	assign up       = {1'b0, pos} - {1'b0, base_q};
	assign dn       = {1'b0, base_q} - {1'b0, pos};
	assign in_win   = pkt_ok && ge && (up < WIN_P);
	assign below    = pkt_ok && !ge && (dn <= WIN_P);
	assign slot_sum = {1'b0, base_slot_q} + {1'b0, up[SW-1:0]};
	assign slot     = (slot_sum >= WIN_S) ? SW'(slot_sum - WIN_S) : slot_sum[SW-1:0];
	assign store_en = in_win && !present_q[slot];
	assign other_ack = below || store_en;
	assign sat      = base_q == srrw_pkg::POS_MAX;
	assign out_free = !out_valid_q || out_ready;
	assign adv      = (cmd.eval_hit || cmd.emit_mem) && !sat;

	assign stat.hit      = in_win && (up == '0);
	assign stat.sat      = sat;
	assign stat.pres     = present_q[base_slot_q];
	assign stat.nfull    = n_q == N_FULL;
	assign stat.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			seq_q <= seq;
			tag_q <= tag;
			ok_q  <= checksum_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_other && store_en) begin
			mem[slot] <= tag_q;
		end
		if (cmd.take) begin
			rdata_q <= mem[base_slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= srrw_pkg::BASE_RST;
			base_slot_q <= SLOT_RST;
			present_q   <= '0;
			n_q         <= '0;
		end else begin
			if (adv) begin
				base_q      <= base_q + PW'(1);
				base_slot_q <= (base_slot_q == SLOT_TOP) ? '0 : base_slot_q + SW'(1);
			end
			if (cmd.eval_other && store_en) begin
				present_q[slot] <= 1'b1;
			end
			if (cmd.take) begin
				present_q[base_slot_q] <= 1'b0;
			end
			if (cmd.eval_hit) begin
				n_q <= NW'(1);
			end else if (cmd.emit_mem) begin
				n_q <= n_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.eval_hit || cmd.eval_other || cmd.emit_mem || cmd.emit_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_hit) begin
			kind_q      <= srrw_pkg::KIND_DELIV;
			position_q  <= pos;
			handle_q    <= tag_q;
			ack_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else if (cmd.emit_mem) begin
			kind_q      <= srrw_pkg::KIND_DELIV;
			position_q  <= base_q;
			handle_q    <= rdata_q;
			ack_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else if (cmd.eval_other) begin
			kind_q      <= srrw_pkg::KIND_ACK;
			position_q  <= other_ack ? pos : '0;
			handle_q    <= '0;
			ack_valid_q <= other_ack;
			last_q      <= 1'b1;
		end else if (cmd.emit_ack) begin
			kind_q      <= srrw_pkg::KIND_ACK;
			position_q  <= pos;
			handle_q    <= '0;
			ack_valid_q <= 1'b1;
			last_q      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign position  = position_q;
	assign handle    = handle_q;
	assign ack_valid = ack_valid_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ----- rtl/selective_repeat_receiver_window_core.sv -----
// Top level of the selective-repeat receiver window.
// Input channel (in_valid/in_ready) takes one packet item: seq, tag, checksum_ok.
// Output channel (out_valid/out_ready) returns result items: zero or more in-order
// deliveries (kind 0) followed by exactly one ack result (kind 1, last 1).
// One item is worked on at a time; in_ready is high only while the controller idles.
// The first result is registered in the evaluation state that follows acceptance,
// once the output register is free. A packet that is not at the receive base passes
// through the idle and evaluation states only, its ack result leaving through the
// output register while the next item is already accepted. A packet at the base is
// delivered in the evaluation state; each of the k buffered consecutive packets
// drained (at most WINDOW-1) then takes a check state that tests its slot flag and
// reads the handle memory and an emit state that delivers it; the final slot test
// and the ack follow, and that test is skipped once the base saturates at 65535.
// A stalled receiver (out_ready low) holds the result in the output register and
// stalls the controller in any state that would emit until the result is taken; nothing is lost.
// Reset sets the receive base to 1 and clears all slot flags at once; the handle
// memory is not cleared, since an entry is read only while its flag is set.
`default_nettype none
module selective_repeat_receiver_window_core #(
	parameter int WINDOW = srrw_pkg::WINDOW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [srrw_pkg::POS_W-1:0]   seq,
	input  wire logic [srrw_pkg::POS_W-1:0]   tag,
	input  wire logic                         checksum_ok,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              kind,
	output logic [srrw_pkg::POS_W-1:0]        position,
	output logic [srrw_pkg::POS_W-1:0]        handle,
	output logic                              ack_valid,
	output logic                              last
);

	srrw_pkg::srrw_cmd_t  cmd;
	srrw_pkg::srrw_stat_t stat;

	srrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srrw_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.seq         (seq),
		.tag         (tag),
		.checksum_ok (checksum_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.position    (position),
		.handle      (handle),
		.ack_valid   (ack_valid),
		.last        (last),
		.cmd         (cmd),
		.stat        (stat)
	);

	a_deliv_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == srrw_pkg::KIND_DELIV) |-> !last && !ack_valid)
		else $error("delivery item carries ack flags");

	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == srrw_pkg::KIND_ACK) |-> last && (handle == '0))
		else $error("ack item malformed");

	a_noack_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == srrw_pkg::KIND_ACK) && !ack_valid |-> position == '0)
		else $error("ack item without ack carries a position");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted before evaluation");

endmodule
`default_nettype wire
